// ===== rtl/bbf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the blocked Bloom filter.
// No dependencies; used by scoped names from the top level and the testbench.
package bbf_pkg;

    localparam int NUM_FILTERS   = 16;
    localparam int MAX_SIZE_LOG2 = 16;
    localparam int BLOCK_BYTES   = 512;
    localparam int SEL_W         = 4;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int WEIGHT_W      = 21;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET  = 5'd16;
    localparam logic [CFG_W-1:0] HASH_COUNT_RESET = 5'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_LOG2  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HASH_COUNT = 1'b1;

    localparam logic [11:0] INBLOCK_MASK = 12'hFFF;

    localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2  = 32'h1b873593;
    localparam logic [31:0] MUR_C3  = 32'h85ebca6b;
    localparam logic [31:0] MUR_C4  = 32'hc2b2ae35;
    localparam logic [31:0] MUR_ADD = 32'he6546b64;
    localparam logic [31:0] MUR_MUL5 = 32'd5;
    localparam logic [31:0] MUR_LEN = 32'd8;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_WEIGHT = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_HASH,
        S_BLK,
        S_RD,
        S_MOD,
        S_WRD,
        S_WLAST,
        S_OUT
    } t_state;

endpackage

// ===== rtl/blocked_bloom_filter_top.sv =====
`timescale 1ns / 1ps
// Top level of the blocked Bloom filter: sequencer, shared hash multiplier and store.
// Depends on bbf_pkg and bbf_ram.
//
// The block takes one request beat at a time and holds o_in_stall high until
// that request has finished. Insert and lookup run MurmurHash3 on one shared
// 32x32 multiplier, form the block address, then take each hash bit with a read of
// the byte store and a check or write-back, and then present the result; a lookup
// stops at the first clear bit. A weight request reads the store one byte a cycle.
// A clear request writes one byte a cycle over the whole store. The same clearing
// pass runs after reset, and no request beat is taken until it ends; configuration
// writes are taken at any time. Every request gives exactly one result beat; a
// finished result sits in an output register, so a new request is taken while it
// waits.
module blocked_bloom_filter_top #(
    parameter int MAX_SIZE_LOG2 = bbf_pkg::MAX_SIZE_LOG2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [63:0]                     i_key,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic [bbf_pkg::WEIGHT_W-1:0]    o_weight,
    input  logic                            i_cfg_we,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bbf_pkg::CFG_W-1:0]       i_cfg_data
);

    // Byte offsets within one sub-filter region, and the store geometry.
    localparam int OW     = (MAX_SIZE_LOG2 > 3) ? MAX_SIZE_LOG2 - 3 : 1;
    localparam int HW     = OW + 3;
    localparam int REGION = (2 ** (MAX_SIZE_LOG2 - 3)) + bbf_pkg::BLOCK_BYTES;
    localparam int STORE  = bbf_pkg::NUM_FILTERS * REGION;
    localparam int AW     = $clog2(STORE);
    localparam int BLK_SH = $clog2(bbf_pkg::BLOCK_BYTES);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [15:0] fold16(input logic [63:0] v);
        fold16 = v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48];
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int b = 0; b < 8; b++) begin
            c = c + 4'(v[b]);
        end
        popcount8 = c;
    endfunction

    bbf_pkg::t_state             r_state, n_state;
    bbf_pkg::t_req               r_req, n_req;
    logic [bbf_pkg::CFG_W-1:0]   r_size, n_size;
    logic [bbf_pkg::CFG_W-1:0]   r_hc, n_hc;
    logic [63:0]                 r_key, n_key;
    logic [63:0]                 r_skey, n_skey;
    logic [31:0]                 r_h, n_h;
    logic [31:0]                 r_k, n_k;
    logic [2:0]                  r_step, n_step;
    logic [AW-1:0]               r_blk, n_blk;
    logic [2:0]                  r_bit0, n_bit0;
    logic [4:0]                  r_kidx, n_kidx;
    logic                        r_hit, n_hit;
    logic [bbf_pkg::WEIGHT_W-1:0] r_wacc, n_wacc;
    logic [AW-1:0]               r_caddr, n_caddr;
    logic [OW-1:0]               r_wi, n_wi;
    logic [bbf_pkg::SEL_W-1:0]   r_wf, n_wf;
    logic [AW-1:0]               r_wbase, n_wbase;
    logic                        r_pc_vld, n_pc_vld;
    logic                        r_resp, n_resp;
    logic                        r_ovalid, n_ovalid;
    logic                        r_ohit, n_ohit;
    logic [bbf_pkg::WEIGHT_W-1:0] r_oweight, n_oweight;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [7:0]                  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [7:0]                  ram_rdata;

    logic [bbf_pkg::CFG_W-1:0]   eff_size;
    logic [bbf_pkg::CFG_W-1:0]   hc_eff;
    logic [HW-1:0]               size_mask;
    logic [OW:0]                 nbytes_full;
    logic [OW-1:0]               nmask;
    logic [31:0]                 mul_a, mul_b, hfin, t_mix;
    logic [63:0]                 mul_full;
    logic [HW-1:0]               h0;
    logic [15:0]                 key_fold;
    logic [15:0]                 skey_fold;
    logic [bbf_pkg::SEL_W-1:0]   sel;
    logic [AW-1:0]               sel_base;
    logic [11:0]                 h1;
    logic [AW-1:0]               bit_addr;
    logic [2:0]                  bit_idx;
    logic [7:0]                  bmask;
    logic                        last_bit;

    bbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective size clamps to the range the store was built for.
    always_comb begin
        if (r_size < 5'd3) begin
            eff_size = 5'd3;
        end else if (r_size > 5'(MAX_SIZE_LOG2)) begin
            eff_size = 5'(MAX_SIZE_LOG2);
        end else begin
            eff_size = r_size;
        end
        hc_eff      = (r_hc == '0) ? 5'd1 : r_hc;
        size_mask   = (HW'(1) << eff_size) - HW'(1);
        nbytes_full = ((OW + 1)'(1) << (eff_size - 5'd3)) - (OW + 1)'(1);
        nmask       = nbytes_full[OW-1:0];
    end

    // Shared multiplier: the step counter picks operands for each hash round.
    always_comb begin
        t_mix = '0;
        unique case (r_step)
            3'd0: begin mul_a = r_key[31:0];                 mul_b = bbf_pkg::MUR_C1; end
            3'd1: begin mul_a = rotl(r_k, 15);               mul_b = bbf_pkg::MUR_C2; end
            3'd2: begin mul_a = rotl(r_h ^ r_k, 13);         mul_b = bbf_pkg::MUR_MUL5; end
            3'd3: begin mul_a = r_key[63:32];                mul_b = bbf_pkg::MUR_C1; end
            3'd4: begin mul_a = rotl(r_k, 15);               mul_b = bbf_pkg::MUR_C2; end
            3'd5: begin mul_a = rotl(r_h ^ r_k, 13);         mul_b = bbf_pkg::MUR_MUL5; end
            3'd6: begin
                t_mix = r_h ^ bbf_pkg::MUR_LEN;
                mul_a = t_mix ^ (t_mix >> 16);
                mul_b = bbf_pkg::MUR_C3;
            end
            default: begin
                mul_a = r_h ^ (r_h >> 13);
                mul_b = bbf_pkg::MUR_C4;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    // Primary bit, sub-filter base and the current in-block bit.
    always_comb begin
        hfin      = r_h ^ (r_h >> 16);
        h0        = hfin[HW-1:0] & size_mask;
        key_fold  = fold16(r_key);
        skey_fold = fold16(r_skey);
        sel       = key_fold[bbf_pkg::SEL_W-1:0];
        sel_base  = (AW'(sel) << (MAX_SIZE_LOG2 - 3)) + (AW'(sel) << BLK_SH);
        h1        = skey_fold[11:0] & bbf_pkg::INBLOCK_MASK;
        if (r_kidx == '0) begin
            bit_addr = r_blk;
            bit_idx  = r_bit0;
        end else begin
            bit_addr = r_blk + AW'(h1[11:3]);
            bit_idx  = h1[2:0];
        end
        bmask    = 8'(1) << bit_idx;
        last_bit = (6'(r_kidx) + 6'd1) >= 6'(hc_eff);
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_size    = r_size;
        n_hc      = r_hc;
        n_key     = r_key;
        n_skey    = r_skey;
        n_h       = r_h;
        n_k       = r_k;
        n_step    = r_step;
        n_blk     = r_blk;
        n_bit0    = r_bit0;
        n_kidx    = r_kidx;
        n_hit     = r_hit;
        n_wacc    = r_wacc;
        n_caddr   = r_caddr;
        n_wi      = r_wi;
        n_wf      = r_wf;
        n_wbase   = r_wbase;
        n_resp    = r_resp;
        n_ovalid  = r_ovalid;
        n_ohit    = r_ohit;
        n_oweight = r_oweight;
        n_pc_vld  = (r_state == bbf_pkg::S_WRD);
        ram_we    = 1'b0;
        ram_waddr = r_caddr;
        ram_wdata = '0;
        ram_raddr = bit_addr;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bbf_pkg::CFG_IDX_SIZE_LOG2:  n_size = i_cfg_data;
                bbf_pkg::CFG_IDX_HASH_COUNT: n_hc   = i_cfg_data;
                default: ;
            endcase
        end

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        // Weight data returns in the cycle after its read address.
        if (r_pc_vld) begin
            n_wacc = r_wacc + bbf_pkg::WEIGHT_W'(popcount8(ram_rdata));
        end

        unique case (r_state)
            bbf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = bbf_pkg::t_req'(i_req_type);
                    n_key  = i_key;
                    n_skey = i_key >> 1;
                    n_h    = '0;
                    n_step = '0;
                    n_kidx = '0;
                    n_hit  = 1'b0;
                    n_wacc = '0;
                    n_resp = 1'b1;
                    unique case (bbf_pkg::t_req'(i_req_type))
                        bbf_pkg::REQ_CLEAR: begin
                            n_caddr = '0;
                            n_state = bbf_pkg::S_CLR;
                        end
                        bbf_pkg::REQ_WEIGHT: begin
                            n_wi    = '0;
                            n_wf    = '0;
                            n_wbase = '0;
                            n_state = bbf_pkg::S_WRD;
                        end
                        default: n_state = bbf_pkg::S_HASH;
                    endcase
                end
            end
            bbf_pkg::S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_caddr;
                ram_wdata = '0;
                if (r_caddr == AW'(STORE - 1)) begin
                    n_state = r_resp ? bbf_pkg::S_OUT : bbf_pkg::S_IDLE;
                end else begin
                    n_caddr = r_caddr + AW'(1);
                end
            end
            bbf_pkg::S_HASH: begin
                case (r_step)
                    3'd2, 3'd5: n_h = mul_full[31:0] + bbf_pkg::MUR_ADD;
                    3'd6, 3'd7: n_h = mul_full[31:0];
                    default:    n_k = mul_full[31:0];
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = bbf_pkg::S_BLK;
                end
            end
            bbf_pkg::S_BLK: begin
                n_blk   = sel_base + AW'(h0[HW-1:3]);
                n_bit0  = h0[2:0];
                n_state = bbf_pkg::S_RD;
            end
            bbf_pkg::S_RD: begin
                n_state = bbf_pkg::S_MOD;
            end
            bbf_pkg::S_MOD: begin
                if (r_req == bbf_pkg::REQ_INSERT) begin
                    ram_we    = 1'b1;
                    ram_waddr = bit_addr;
                    ram_wdata = ram_rdata | bmask;
                end
                if (r_req == bbf_pkg::REQ_LOOKUP && (ram_rdata & bmask) == '0) begin
                    n_hit   = 1'b0;
                    n_state = bbf_pkg::S_OUT;
                end else if (last_bit) begin
                    n_hit   = (r_req == bbf_pkg::REQ_LOOKUP);
                    n_state = bbf_pkg::S_OUT;
                end else begin
                    n_kidx = r_kidx + 5'd1;
                    if (r_kidx != '0) begin
                        n_skey = r_skey >> 1;
                    end
                    n_state = bbf_pkg::S_RD;
                end
            end
            bbf_pkg::S_WRD: begin
                ram_raddr = r_wbase + AW'(r_wi);
                if (r_wi == nmask) begin
                    n_wi    = '0;
                    n_wf    = r_wf + bbf_pkg::SEL_W'(1);
                    n_wbase = r_wbase + AW'(REGION);
                    if (r_wf == bbf_pkg::SEL_W'(bbf_pkg::NUM_FILTERS - 1)) begin
                        n_state = bbf_pkg::S_WLAST;
                    end
                end else begin
                    n_wi = r_wi + OW'(1);
                end
            end
            bbf_pkg::S_WLAST: begin
                n_state = bbf_pkg::S_OUT;
            end
            bbf_pkg::S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid  = 1'b1;
                    n_ohit    = r_hit;
                    n_oweight = r_wacc;
                    n_state   = bbf_pkg::S_IDLE;
                end
            end
            default: n_state = bbf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bbf_pkg::S_CLR;
            r_size   <= bbf_pkg::SIZE_LOG2_RESET;
            r_hc     <= bbf_pkg::HASH_COUNT_RESET;
            r_caddr  <= '0;
            r_resp   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pc_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_hc     <= n_hc;
            r_caddr  <= n_caddr;
            r_resp   <= n_resp;
            r_ovalid <= n_ovalid;
            r_pc_vld <= n_pc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_skey    <= n_skey;
        r_h       <= n_h;
        r_k       <= n_k;
        r_step    <= n_step;
        r_blk     <= n_blk;
        r_bit0    <= n_bit0;
        r_kidx    <= n_kidx;
        r_hit     <= n_hit;
        r_wacc    <= n_wacc;
        r_wi      <= n_wi;
        r_wf      <= n_wf;
        r_wbase   <= n_wbase;
        r_ohit    <= n_ohit;
        r_oweight <= n_oweight;
    end

    assign o_in_stall  = (r_state != bbf_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_hit       = r_ohit;
    assign o_weight    = r_oweight;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the block stayed idle");

    a_hit_weight_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_weight != '0))
        else $error("result carries both a hit and a weight");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr <= AW'(STORE - 1)))
        else $error("store write beyond the last byte");

    a_no_write_in_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbf_pkg::S_WRD || r_state == bbf_pkg::S_WLAST) |-> !ram_we)
        else $error("store written during a weight walk");

    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbf_pkg::S_MOD) |-> (r_kidx < hc_eff))
        else $error("hash bit index ran past the hash count");
`endif

endmodule

// ===== rtl/bbf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/tb_blocked_bloom_filter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for blocked_bloom_filter_top: a shadow copy of the filter
// store predicts each result beat, and the bench checks every beat in order.
// Depends on bbf_pkg and the RTL of blocked_bloom_filter_top.

// The shadow filter mirrors the byte store and both registers. It turns every
// accepted request beat into an expected result and checks result beats in order.
class bloom_shadow;
    localparam int REGION_BYTES = (1 << bbf_pkg::MAX_SIZE_LOG2) / 8 + bbf_pkg::BLOCK_BYTES;
    localparam int STORE_BYTES  = bbf_pkg::NUM_FILTERS * REGION_BYTES;

    typedef struct {
        logic                         hit;
        logic [bbf_pkg::WEIGHT_W-1:0] weight;
    } t_answer;

    byte unsigned store[STORE_BYTES];
    logic [4:0]   size_log2;
    logic [4:0]   hash_count;
    t_answer      answers[$];
    int           mismatches;
    int           results_seen;

    function new();
        foreach (store[i]) store[i] = 0;
        size_log2    = bbf_pkg::SIZE_LOG2_RESET;
        hash_count   = bbf_pkg::HASH_COUNT_RESET;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void write_reg(logic [bbf_pkg::CFG_IDX_W-1:0] idx, logic [4:0] value);
        if (idx == bbf_pkg::CFG_IDX_SIZE_LOG2) size_log2 = value;
        else if (idx == bbf_pkg::CFG_IDX_HASH_COUNT) hash_count = value;
    endfunction

    function int eff_size();
        if (size_log2 < 3) return 3;
        if (size_log2 > bbf_pkg::MAX_SIZE_LOG2) return bbf_pkg::MAX_SIZE_LOG2;
        return size_log2;
    endfunction

    static function logic [31:0] rotl32(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    static function logic [15:0] key_fold(logic [63:0] v);
        return v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48];
    endfunction

    // MurmurHash3 x86_32, seed 0, over the eight key bytes in little-endian order.
    static function logic [31:0] key_murmur(logic [63:0] key);
        logic [31:0] h;
        logic [31:0] k;
        h = 32'd0;
        for (int b = 0; b < 2; b++) begin
            k = key[32*b +: 32];
            k = k * bbf_pkg::MUR_C1;
            k = rotl32(k, 15);
            k = k * bbf_pkg::MUR_C2;
            h = h ^ k;
            h = rotl32(h, 13);
            h = h * 32'd5 + bbf_pkg::MUR_ADD;
        end
        h = h ^ 32'd8;
        h = h ^ (h >> 16);
        h = h * bbf_pkg::MUR_C3;
        h = h ^ (h >> 13);
        h = h * bbf_pkg::MUR_C4;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function void note_request(bbf_pkg::t_req req, logic [63:0] key);
        t_answer     ans;
        int          base;
        int          nbytes;
        int          bit_idx;
        logic [31:0] h0;
        ans.hit    = 1'b0;
        ans.weight = '0;
        case (req)
            bbf_pkg::REQ_CLEAR: begin
                foreach (store[i]) store[i] = 0;
            end
            bbf_pkg::REQ_WEIGHT: begin
                int total;
                total  = 0;
                nbytes = 1 << (eff_size() - 3);
                for (int f = 0; f < bbf_pkg::NUM_FILTERS; f++)
                    for (int i = 0; i < nbytes; i++)
                        total += $countones(store[f * REGION_BYTES + i]);
                ans.weight = bbf_pkg::WEIGHT_W'(total);
            end
            default: begin
                h0   = key_murmur(key) & ((32'd1 << eff_size()) - 1);
                base = int'(key_fold(key) & 16'd15) * REGION_BYTES + int'(h0 >> 3);
                if (req == bbf_pkg::REQ_INSERT) begin
                    store[base] |= 8'(1 << h0[2:0]);
                    for (int k = 1; k < hash_count; k++) begin
                        bit_idx = key_fold(key >> k) & 16'hFFF;
                        store[base + (bit_idx >> 3)] |= 8'(1 << (bit_idx & 7));
                    end
                end else begin
                    ans.hit = store[base][h0[2:0]];
                    for (int k = 1; ans.hit && k < hash_count; k++) begin
                        bit_idx = key_fold(key >> k) & 16'hFFF;
                        if (!store[base + (bit_idx >> 3)][bit_idx & 7]) ans.hit = 1'b0;
                    end
                end
            end
        endcase
        answers.push_back(ans);
    endfunction

    function void check_result(logic hit, logic [bbf_pkg::WEIGHT_W-1:0] weight);
        t_answer exp_ans;
        results_seen++;
        if (answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result beat with nothing expected: hit=%0d weight=%0d", hit, weight);
            return;
        end
        exp_ans = answers.pop_front();
        if (hit !== exp_ans.hit || weight !== exp_ans.weight) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on result %0d: expected hit=%0d weight=%0d, got hit=%0d weight=%0d",
                         results_seen, exp_ans.hit, exp_ans.weight, hit, weight);
        end
    endfunction

    function int pending();
        return answers.size();
    endfunction
endclass

module tb_blocked_bloom_filter_top;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [1:0]                    i_req_type;
    logic [63:0]                   i_key;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_hit;
    logic [bbf_pkg::WEIGHT_W-1:0]  o_weight;
    logic                          i_cfg_we;
    logic [bbf_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [bbf_pkg::CFG_W-1:0]     i_cfg_data;

    bloom_shadow  shadow;
    logic [63:0]  inserted_keys[$];
    bit           idling_on;
    int           beats_sent;
    int           phases_run;

    blocked_bloom_filter_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_hit      (o_hit),
        .o_weight   (o_weight),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The reset clearing pass plus one full-size weight and two clear requests make
    // up most of the run, and the timeout leaves ample headroom.
    initial begin
        #40_000_000;
        $display("Timeout with %0d results still expected", shadow.pending());
        $display("FAIL blocked_bloom_filter_top");
        $finish;
    end

    // Result side: check each accepted result beat, then pick the next stall value.
    // The stall is drawn independently of o_out_valid, in every phase with idling on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) shadow.check_result(o_hit, o_weight);
        i_out_stall <= idling_on && ($urandom_range(99) < 25);
    end

    // Sends one request beat and holds it until the block takes it. The predictor
    // sees the beat in acceptance order, which is also the order of the results.
    task automatic send_request(bbf_pkg::t_req req, logic [63:0] key);
        while (idling_on && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.note_request(req, key);
        if (req == bbf_pkg::REQ_INSERT) inserted_keys.push_back(key);
        beats_sent++;
    endtask

    // Waits until every expected result has come back, then lets the sequencer settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_config(logic [4:0] size_val, logic [4:0] hash_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= bbf_pkg::CFG_IDX_SIZE_LOG2;
        i_cfg_data  <= size_val;
        @(posedge i_clk);
        i_cfg_index <= bbf_pkg::CFG_IDX_HASH_COUNT;
        i_cfg_data  <= hash_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow.write_reg(bbf_pkg::CFG_IDX_SIZE_LOG2, size_val);
        shadow.write_reg(bbf_pkg::CFG_IDX_HASH_COUNT, hash_val);
        phases_run++;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // One random phase. Most beats are inserts and lookups of keys already inserted,
    // so lookups reach the all-bits-set path; the rest look up random keys, ask for the
    // weight (only at small sizes, where a store walk stays short) or clear the store.
    task automatic run_random_phase(int count, bit with_clear);
        int   pick;
        bit   weight_ok;
        weight_ok = shadow.eff_size() <= 11;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (with_clear && n == count / 2)
                send_request(bbf_pkg::REQ_CLEAR, rand_key());
            else if (pick < 40)
                send_request(bbf_pkg::REQ_INSERT, rand_key());
            else if (pick < 75 && inserted_keys.size() > 0)
                send_request(bbf_pkg::REQ_LOOKUP,
                             inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
            else if (pick < 90 || !weight_ok)
                send_request(bbf_pkg::REQ_LOOKUP, rand_key());
            else
                send_request(bbf_pkg::REQ_WEIGHT, rand_key());
        end
    endtask

    initial begin
        shadow      = new();
        idling_on   = 1'b0;
        beats_sent  = 0;
        phases_run  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = bbf_pkg::REQ_CLEAR;
        i_key       = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = bbf_pkg::CFG_IDX_SIZE_LOG2;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: key extremes, a full-size weight,
        // and a clear followed by a lookup that must now miss.
        send_request(bbf_pkg::REQ_INSERT, 64'h0);
        send_request(bbf_pkg::REQ_INSERT, '1);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h0);
        send_request(bbf_pkg::REQ_LOOKUP, '1);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h1);
        send_request(bbf_pkg::REQ_INSERT, 64'h8000_0000_0000_0001);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0001);
        send_request(bbf_pkg::REQ_WEIGHT, 64'h0);
        send_request(bbf_pkg::REQ_CLEAR, '1);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h0);
        wait_drained();

        // Size below the minimum and a hash count of zero both clamp.
        write_config(5'd0, 5'd0);
        send_request(bbf_pkg::REQ_WEIGHT, 64'h0);
        send_request(bbf_pkg::REQ_INSERT, 64'h0123_4567_89AB_CDEF);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h0123_4567_89AB_CDEF);
        send_request(bbf_pkg::REQ_WEIGHT, 64'h0);
        wait_drained();

        // Size above the maximum clamps; the largest hash count is used as written.
        write_config(5'd31, 5'd31);
        send_request(bbf_pkg::REQ_INSERT, 64'hFFFF_0000_FFFF_0000);
        send_request(bbf_pkg::REQ_LOOKUP, 64'hFFFF_0000_FFFF_0000);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h0000_FFFF_0000_FFFF);
        wait_drained();

        write_config(5'd3, 5'd17);
        send_request(bbf_pkg::REQ_INSERT, 64'h5555_AAAA_5555_AAAA);
        send_request(bbf_pkg::REQ_LOOKUP, 64'h5555_AAAA_5555_AAAA);
        send_request(bbf_pkg::REQ_WEIGHT, 64'h0);
        wait_drained();

        // Random part: the first phase runs with no idling on either side, the
        // others idle at random. The sixth phase carries a clear.
        for (int p = 0; p < 9; p++) begin
            idling_on = (p != 0);
            if (p == 0) write_config(5'd10, 5'd16);
            else if (p == 8) write_config(5'd16, 5'd1);
            else write_config(5'($urandom_range(31)), 5'($urandom_range(31)));
            run_random_phase(70, p == 5);
            wait_drained();
        end

        $display("Sent %0d request beats over %0d register settings, checked %0d results",
                 beats_sent, phases_run, shadow.results_seen);
        $display("Mismatches: %0d, results still expected: %0d",
                 shadow.mismatches, shadow.pending());
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("PASS blocked_bloom_filter_top");
        else
            $display("FAIL blocked_bloom_filter_top");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/bbf_pkg.sv
rtl/bbf_ram.sv
rtl/blocked_bloom_filter_top.sv
bench/tb_blocked_bloom_filter_top.sv
